/* rtl/sha_pkg.sv */
// sha_pkg: constants, types and round functions shared by the sha-256 hasher
// depends on nothing; used by sha_round and sha256_byte_stream_hasher
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [7:0] state_t;

  localparam state_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadByte = 8'h80;

  // control from sequencer to round unit
  typedef struct packed {
    logic       load;   // copy chain into working vars
    logic       step;   // perform one round
    logic [5:0] rnd;    // round number
    word_t      w_in;   // message word for rounds below 16
  } round_ctl_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction

endpackage

/* rtl/sha_ram.sv */
// sha_ram: generic single-port ram with registered read
// no dependencies
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/sha_round.sv */
// sha_round: shared sha-256 round unit with working vars and schedule window
// depends on sha_pkg
module sha_round (
  input  logic               clk,
  input  sha_pkg::round_ctl_t ctl,
  input  sha_pkg::state_t    chain,
  output sha_pkg::state_t    vars
);

  sha_pkg::state_t vars_r, vars_nxt;
  sha_pkg::word_t  win_r [16];
  sha_pkg::word_t  w, x2, x15, sg0, sg1, t1, t2, e, a;

  // message word, from input or rolling schedule
  always_comb begin
    x2  = win_r[4'(ctl.rnd - 6'd2)];
    x15 = win_r[4'(ctl.rnd - 6'd15)];
    sg1 = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
    sg0 = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
    if (ctl.rnd < 6'd16) begin
      w = ctl.w_in;
    end else begin
      w = win_r[ctl.rnd[3:0]] + sg1 + win_r[4'(ctl.rnd - 6'd7)] + sg0;
    end
  end

  // round compression
  always_comb begin
    e  = vars_r[4];
    a  = vars_r[0];
    t1 = vars_r[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
       + ((e & vars_r[5]) ^ (~e & vars_r[6])) + sha_pkg::round_k(ctl.rnd) + w;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
       + ((a & vars_r[1]) ^ (a & vars_r[2]) ^ (vars_r[1] & vars_r[2]));
    vars_nxt = vars_r;
    if (ctl.load) begin
      vars_nxt = chain;
    end else if (ctl.step) begin
      vars_nxt[7] = vars_r[6];
      vars_nxt[6] = vars_r[5];
      vars_nxt[5] = vars_r[4];
      vars_nxt[4] = vars_r[3] + t1;
      vars_nxt[3] = vars_r[2];
      vars_nxt[2] = vars_r[1];
      vars_nxt[1] = vars_r[0];
      vars_nxt[0] = t1 + t2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
    if (ctl.step && !ctl.load) begin
      win_r[ctl.rnd[3:0]] <= w;
    end
  end

  assign vars = vars_r;

endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// sha256_byte_stream_hasher: top level, byte buffer, padding and round sequencer
// depends on sha_pkg, sha_ram, sha_round
//
// usage:
//   input channel: in_data_byte, in_has_byte, in_end_of_message with
//   in_valid / in_stall. one byte per transaction; end_of_message finishes
//   the message (a byte in the same transaction is taken first).
//   output channel: eight transactions per message, out_digest_word with
//   out_word_index 0..7 and out_last_word on the eighth.
//   flow: a byte that neither fills a block nor ends the message is taken
//   without stalling. a byte that fills a block stalls the input for a load
//   step, then for each of the first 16 rounds a read of its four bytes from
//   the single-port block ram before its round, then the other 48 rounds
//   back to back, and an add into the chain. end of message adds padding
//   writes, one or two compressions, then 8 output transactions.
//   reset: chaining words return to the initial hash, byte count clears.
//   a stalled output holds its word; no input is taken until all eight
//   digest words have been delivered.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_LEN, S_LOAD, S_FETCH, S_ROUND, S_ADD, S_OUT
  } fsm_state_t;

  fsm_state_t      state_r;
  logic [60:0]     total_r;
  logic            eom_r, final_r;
  logic [6:0]      cnt_r;      // pad / length position; bit 6 marks second pad block, or read data pending in fetch
  logic [5:0]      rnd_r;
  logic [1:0]      sub_r;      // byte within word while fetching
  logic [23:0]     wacc_r;
  sha_pkg::word_t  wfull_r;
  sha_pkg::state_t chain_r;
  logic [2:0]      oidx_r;

  logic            ram_we;
  logic [5:0]      ram_addr;
  logic [7:0]      ram_wdata, ram_rdata;
  sha_pkg::round_ctl_t ctl;
  sha_pkg::state_t vars;
  logic [63:0]     bits;
  logic            accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign bits = {total_r, 3'b000};

  sha_ram #(.Width(8), .Depth(64)) u_buf (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  sha_round u_round (.clk(clk), .ctl(ctl), .chain(chain_r), .vars(vars));

  // block buffer port and round control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = total_r[5:0];
    ram_wdata = in_data_byte;
    ctl.load  = (state_r == S_LOAD);
    ctl.step  = 1'b0;
    ctl.rnd   = rnd_r;
    ctl.w_in  = wfull_r;
    case (state_r)
      S_IDLE: begin
        ram_we = accept && in_has_byte;
      end
      S_PAD: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_r[5:0];
        ram_wdata = (cnt_r[5:0] == total_r[5:0]) ? sha_pkg::PadByte : 8'h00;
      end
      S_LEN: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_r[5:0];
        ram_wdata = 8'(bits >> (6'd56 - {cnt_r[2:0], 3'b000}));
      end
      S_FETCH: begin
        ram_addr = {rnd_r[3:0], sub_r};
      end
      S_ROUND: begin
        ctl.step = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      chain_r <= sha_pkg::InitHash;
      eom_r   <= 1'b0;
      final_r <= 1'b0;
      cnt_r   <= '0;
      rnd_r   <= '0;
      sub_r   <= '0;
      oidx_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            eom_r <= in_end_of_message;
            if (in_has_byte) begin
              total_r <= total_r + 61'd1;
            end
            if (in_has_byte && total_r[5:0] == 6'd63) begin
              state_r <= S_LOAD;
            end else if (in_end_of_message) begin
              cnt_r   <= {1'b0, (in_has_byte ? total_r[5:0] + 6'd1 : total_r[5:0])};
              state_r <= S_PAD;
            end
          end
        end
        // 0x80 then zeros to end of block or to the length field
        S_PAD: begin
          if (total_r[5:0] > 6'd55 && !cnt_r[6]) begin
            if (cnt_r[5:0] == 6'd63) begin
              final_r <= 1'b0;
              state_r <= S_LOAD;
            end
            cnt_r <= cnt_r + 7'd1;
          end else if (cnt_r[5:0] == 6'd55) begin
            cnt_r   <= 7'd56;
            state_r <= S_LEN;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_LEN: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r[5:0] == 6'd63) begin
            final_r <= 1'b1;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd_r   <= '0;
          sub_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_FETCH;
        end
        // read four bytes; read data is registered, so it arrives the cycle after its address
        S_FETCH: begin
          if (cnt_r[6]) begin
            wacc_r <= {wacc_r[15:0], ram_rdata};
          end
          if (cnt_r[6] && sub_r == 2'd0) begin
            wfull_r <= {wacc_r, ram_rdata};
            cnt_r   <= '0;
            state_r <= S_ROUND;
          end else begin
            cnt_r <= 7'h40;
            sub_r <= sub_r + 2'd1;
          end
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= S_ADD;
          end else if (rnd_r < 6'd15) begin
            sub_r   <= '0;
            state_r <= S_FETCH;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + vars[i];
          end
          if (final_r) begin
            oidx_r  <= '0;
            state_r <= S_OUT;
          end else if (eom_r) begin
            // pad after a message that filled its block, or second pass of a two-block pad (zeros)
            cnt_r   <= (total_r[5:0] > 6'd55) ? 7'h40 : 7'h00;
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              chain_r <= sha_pkg::InitHash;
              total_r <= '0;
              final_r <= 1'b0;
              eom_r   <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = chain_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  // a digest goes out only after the final block compression
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_ADD && final_r))
    else $error("digest without final compression");

  // input is never taken while words are pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

  // the last word closes the output burst
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word && !out_stall |=> !out_valid)
    else $error("output continued after last word");

endmodule

/* tb/sv/tb_sha256_byte_stream_hasher.sv */
// tb_sha256_byte_stream_hasher: self-checking bench for the sha-256 byte stream hasher
// depends on sha_pkg (word_t) and the rtl top sha256_byte_stream_hasher
// directed table of messages first, then random messages, checked by a local digest model
module tb_sha256_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef sha_pkg::word_t word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_has_byte = 1'b0;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0] out_word_index;
  logic       out_last_word;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eom;
  } byte_txn_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_txn_t;

  // idle modes
  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_t;

  localparam word_t RoundK[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam word_t StartHash[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam int CycleLimit = 2000000;

  sha256_byte_stream_hasher dut (.*);

  always #5 clk = ~clk;

  // digest model state
  word_t       chain[8];
  logic [7:0]  blk[64];
  logic [60:0] byte_count;
  digest_txn_t digest_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  idle_mode_t  idle_mode = IdleNone;
  int          sent = 0;

  function automatic word_t ror(word_t v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one 64-round compression of blk into chain
  function automatic void compress_blk();
    word_t a[8];
    word_t w[16];
    word_t wt, t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) a[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      end else begin
        s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
        s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
        wt = w[r&15] + s1 + w[(r-7)&15] + s0;
      end
      w[r&15] = wt;
      t1 = a[7] + (ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25))
           + ((a[4] & a[5]) ^ (~a[4] & a[6])) + RoundK[r] + wt;
      t2 = (ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22))
           + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
      for (int j = 7; j > 0; j--) a[j] = a[j-1];
      a[4] = a[4] + t1;
      a[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += a[i];
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
    byte_count = '0;
  endfunction

  // advance the model by one accepted transaction
  function automatic void hash_txn(byte_txn_t t);
    int pos;
    logic [63:0] bits;
    digest_txn_t d;
    if (t.has) begin
      pos = int'(byte_count[5:0]);
      blk[pos] = t.data;
      byte_count = byte_count + 1'b1;
      if (pos == 63) compress_blk();
    end
    if (!t.eom) return;
    bits = {byte_count, 3'b000};
    pos = int'(byte_count[5:0]);
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin blk[pos] = 8'h00; pos++; end
      compress_blk();
      pos = 0;
    end
    while (pos < 56) begin blk[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.idx = 3'(i);
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    restart_digest();
  endfunction

  // directed table: data, has_byte, end_of_message
  byte_txn_t dir_tab[$];
  // known digest of the empty message, first word
  localparam word_t EmptyWord0 = 32'he3b0c442;

  task automatic build_table();
    dir_tab.push_back('{8'h00, 1'b0, 1'b0});  // idle transaction
    dir_tab.push_back('{8'hff, 1'b0, 1'b1});  // empty message, byte ignored
    dir_tab.push_back('{8'h00, 1'b1, 1'b1});  // one zero byte
    dir_tab.push_back('{8'hff, 1'b1, 1'b1});  // one 0xff byte
    dir_tab.push_back('{8'h61, 1'b1, 1'b0});  // "abc"
    dir_tab.push_back('{8'h62, 1'b1, 1'b0});
    dir_tab.push_back('{8'h00, 1'b0, 1'b0});
    dir_tab.push_back('{8'h63, 1'b1, 1'b1});
    dir_tab.push_back('{8'haa, 1'b1, 1'b0});  // two bytes, end without byte
    dir_tab.push_back('{8'h55, 1'b1, 1'b0});
    dir_tab.push_back('{8'h00, 1'b0, 1'b1});
    dir_tab.push_back('{8'h00, 1'b0, 1'b1});  // empty again, after a digest
  endtask

  // one input transaction, with random sender idling in the send and both idle modes
  task automatic send_txn(byte_txn_t t);
    if ((idle_mode == IdleSend && $urandom_range(99) < 64) ||
        (idle_mode == IdleBoth && $urandom_range(99) < 7)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= t.data;
    in_has_byte <= t.has;
    in_end_of_message <= t.eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    hash_txn(t);
  endtask

  // random message; short, mid-range, or around block and padding boundaries
  task automatic send_message();
    int len;
    byte_txn_t t;
    case ($urandom_range(5))
      0: len = $urandom_range(0, 3);
      1: len = $urandom_range(54, 58);
      2: len = $urandom_range(62, 66);
      3: len = $urandom_range(118, 122);
      default: len = $urandom_range(4, 40);
    endcase
    for (int i = 0; i < len; i++) begin
      t.data = 8'($urandom);
      t.eom = 1'b0;
      t.has = ($urandom_range(9) != 0);
      if (!t.has) i--;
      if (i == len - 1 && $urandom_range(1)) t.eom = 1'b1;
      send_txn(t);
    end
    if (!t.eom || len == 0) begin
      t.data = 8'($urandom);
      t.has = 1'b0;
      t.eom = 1'b1;
      send_txn(t);
    end
  endtask

  // receiver: stall and check
  always @(posedge clk) begin
    digest_txn_t e;
    if (rst_n) begin
      if ((idle_mode == IdleRecv && $urandom_range(99) < 64) ||
          (idle_mode == IdleBoth && $urandom_range(99) < 7))
        out_stall <= 1'b1;
      else
        out_stall <= 1'b0;
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest word %h", out_digest_word);
        end else begin
          e = digest_q.pop_front();
          if (out_digest_word !== e.word || out_word_index !== e.idx ||
              out_last_word !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", e.word, e.idx,
                       e.last, out_digest_word, out_word_index, out_last_word);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_sha256_byte_stream_hasher: errors");
      $finish;
    end
  end

  initial begin
    restart_digest();
    build_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed part
    foreach (dir_tab[i]) begin
      send_txn(dir_tab[i]);
      // the empty-message digest is known outright
      if (i == 1 && (digest_q.size() == 0 || digest_q[0].word != EmptyWord0)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("empty message digest: exp %h got %h", EmptyWord0,
                   (digest_q.size() == 0) ? 32'h0 : digest_q[0].word);
      end
    end
    in_valid <= 1'b0;
    // hold off until every digest word has come
    while (digest_q.size() != 0) @(posedge clk);
    // random part over idling phases, about 270 transactions in all
    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = idle_mode_t'(ph % 4);
      do send_message(); while (sent < dir_tab.size() + (ph + 1) * 43);
    end
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0)
      $display("tb_sha256_byte_stream_hasher: clean");
    else
      $display("tb_sha256_byte_stream_hasher: errors");
    $finish;
  end
endmodule
